@@ rtl/core/tkrl_pkg.sv @@
// tkrl_pkg: request/result types, controller state, command codes and
// control/status structs for the top-k ranked list. No dependencies.
`default_nettype none

package tkrl_pkg;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned KEEP_W  = 5;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;

  localparam logic [0:0] CMD_INSERT = 1'b0;
  localparam logic [0:0] CMD_DUMP   = 1'b1;

  localparam logic [0:0] REG_KEEP_COUNT = 1'b0;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

  typedef struct packed {
    logic [0:0]         command;
    logic [KEY_W-1:0]   entry_key;
    logic [VALUE_W-1:0] entry_value;
    logic [VALUE_W-1:0] threshold;
  } tkrl_req_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count_at_or_above;
    logic [KEY_W-1:0]   out_key;
    logic [VALUE_W-1:0] out_value;
    logic               out_valid;
    logic               last;
  } tkrl_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FLAG,
    ST_SUM,
    ST_DUMP
  } tkrl_state_e;

  typedef struct packed {
    logic insert;
    logic empty;
    logic flag;
    logic sum;
    logic dump;
  } tkrl_ctrl_t;

  typedef struct packed {
    logic empty;
    logic dump_last;
  } tkrl_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/top_k_ranked_list.sv @@
// top_k_ranked_list: top level with the keep count register and its bus
// port; instantiates tkrl_ctrl and tkrl_datapath, depends on tkrl_pkg.
//
//   channel  | signals                              | handshake
//   ---------+--------------------------------------+------------------------------
//   request  | req_i (tkrl_req_t)                   | start high while busy low
//   result   | res_o (tkrl_res_t)                   | res_valid_o, one cycle, no stall
//   config   | psel penable pwrite paddr pwdata ... | psel & penable & pwrite
//
// an insert request runs compare-and-shift on acceptance, then the flag and
// count steps in ST_FLAG and ST_SUM with busy high in both; the count is registered
// a dump of n entries shows one result per cycle from cell 0 of the rotating
// cell row, registered from ST_DUMP, with busy high until the last entry
// a dump of an empty list gives its single result the next cycle, no busy
// reset clears occupancy and the keep count; the receiver cannot stall
`default_nettype none

module top_k_ranked_list
  import tkrl_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire tkrl_req_t         req_i,
  output tkrl_res_t              res_o,
  output logic                   res_valid_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  logic [KEEP_W-1:0] keep_count_q, keep_count_d;
  logic              reg_hit;
  tkrl_ctrl_t        ctrl;
  tkrl_stat_t        stat;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_KEEP_COUNT);
  assign prdata  = reg_hit ? {{(DATA_W-KEEP_W){1'b0}}, keep_count_q} : '0;

  always_comb begin
    keep_count_d = keep_count_q;
    if (psel && penable && pwrite && pready && reg_hit) begin
      keep_count_d = pwdata[KEEP_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_count_q <= '0;
    end else begin
      keep_count_q <= keep_count_d;
    end
  end

  tkrl_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .command_i (req_i.command),
    .stat_i    (stat),
    .busy_o    (busy),
    .ctrl_o    (ctrl)
  );

  tkrl_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .req_i        (req_i),
    .keep_count_i (keep_count_q),
    .stat_o       (stat),
    .res_o        (res_o),
    .res_valid_o  (res_valid_o)
  );

`ifndef NO_ASSERTIONS
  a_ctrl_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctrl.insert, ctrl.empty, ctrl.flag, ctrl.sum, ctrl.dump}))
    else $error("more than one datapath command at once");

  a_insert_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.command == CMD_INSERT) |=> busy)
    else $error("insert request did not raise busy");

  a_insert_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.command == CMD_INSERT)
      |-> ##3 (res_valid_o && res_o.last && !res_o.out_valid))
    else $error("insert result missing or malformed");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.out_valid) |-> res_o.last)
    else $error("result without entry not marked last");
`endif

endmodule

`default_nettype wire

@@ rtl/core/tkrl_ctrl.sv @@
// tkrl_ctrl: state machine that sequences insert and dump requests, with flag and count steps for an insert.
// Depends on tkrl_pkg.
`default_nettype none

module tkrl_ctrl
  import tkrl_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire logic [0:0] command_i,
  input  wire tkrl_stat_t stat_i,
  output logic            busy_o,
  output tkrl_ctrl_t      ctrl_o
);

  tkrl_state_e state_q, state_d;
  logic        accept;

  assign accept = start_i && (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (command_i == CMD_INSERT) begin
            state_d = ST_FLAG;
          end else if (!stat_i.empty) begin
            state_d = ST_DUMP;
          end
        end
      end
      ST_FLAG: begin
        state_d = ST_SUM;
      end
      ST_SUM: begin
        state_d = ST_IDLE;
      end
      ST_DUMP: begin
        if (stat_i.dump_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    busy_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o        = 1'b0;
        ctrl_o.insert = accept && (command_i == CMD_INSERT);
        ctrl_o.empty  = accept && (command_i == CMD_DUMP) && stat_i.empty;
      end
      ST_FLAG: begin
        ctrl_o.flag = 1'b1;
      end
      ST_SUM: begin
        ctrl_o.sum = 1'b1;
      end
      ST_DUMP: begin
        ctrl_o.dump = 1'b1;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/tkrl_datapath.sv @@
// tkrl_datapath: row of ranked key/value cells with per-cell compare and
// shift, threshold count and result register. Depends on tkrl_pkg.
`default_nettype none

module tkrl_datapath
  import tkrl_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tkrl_ctrl_t        ctrl_i,
  input  wire tkrl_req_t         req_i,
  input  wire logic [KEEP_W-1:0] keep_count_i,
  output tkrl_stat_t             stat_o,
  output tkrl_res_t              res_o,
  output logic                   res_valid_o
);

  localparam int unsigned OW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [KEY_W-1:0]   key_q [CAPACITY];
  logic [VALUE_W-1:0] val_q [CAPACITY];
  logic [KEY_W-1:0]   key_d [CAPACITY];
  logic [VALUE_W-1:0] val_d [CAPACITY];

  logic [OW-1:0]       occ_q, occ_d, limit, last_pos;
  logic [OW:0]         occ_inc;
  logic [IW-1:0]       idx_q, idx_d;
  logic [VALUE_W-1:0]  thr_q;
  logic [CAPACITY-1:0] ge, flag_d, flag_q;
  logic [6:0]          sum;
  tkrl_res_t           res_q, res_d;
  logic                res_valid_q, res_valid_d;

  // effective limit: capacity when keep count is zero or too large
  always_comb begin
    if (keep_count_i == '0 || {2'b00, keep_count_i} > 7'(CAPACITY)) begin
      limit = OW'(CAPACITY);
    end else begin
      limit = OW'(keep_count_i);
    end
  end

  assign occ_inc  = {1'b0, occ_q} + (OW+1)'(1);
  assign last_pos = occ_q - OW'(1);

  always_comb begin
    occ_d = occ_q;
    if (ctrl_i.insert && (occ_inc <= {1'b0, limit})) begin
      occ_d = occ_inc[OW-1:0];
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_W-1:0]   ins_key, nxt_key;
    logic [VALUE_W-1:0] ins_val, nxt_val;

    assign ge[i]     = (OW'(i) < occ_q) && (val_q[i] >= req_i.entry_value);
    assign flag_d[i] = (OW'(i) < occ_q) && (val_q[i] >= thr_q);

    if (i == 0) begin : g_head
      assign ins_key = req_i.entry_key;
      assign ins_val = req_i.entry_value;
    end else begin : g_body
      logic prev_ge;
      assign prev_ge = ge[i-1];
      assign ins_key = prev_ge ? req_i.entry_key : key_q[i-1];
      assign ins_val = prev_ge ? req_i.entry_value : val_q[i-1];
    end

    if (i < CAPACITY - 1) begin : g_next
      assign nxt_key = key_q[i+1];
      assign nxt_val = val_q[i+1];
    end else begin : g_tail
      assign nxt_key = key_q[i];
      assign nxt_val = val_q[i];
    end

    // insert: keep, take new entry, or shift down; dump: rotate toward head
    always_comb begin
      key_d[i] = key_q[i];
      val_d[i] = val_q[i];
      if (ctrl_i.insert && !ge[i]) begin
        key_d[i] = ins_key;
        val_d[i] = ins_val;
      end else if (ctrl_i.dump) begin
        if (OW'(i) == last_pos) begin
          key_d[i] = key_q[0];
          val_d[i] = val_q[0];
        end else begin
          key_d[i] = nxt_key;
          val_d[i] = nxt_val;
        end
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      sum = sum + {6'b0, flag_q[i]};
    end
  end

  assign stat_o.empty     = (occ_q == '0);
  assign stat_o.dump_last = (OW'(idx_q) == last_pos);

  always_comb begin
    idx_d       = idx_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    if (ctrl_i.sum) begin
      res_valid_d             = 1'b1;
      res_d                   = '0;
      res_d.count_at_or_above = (sum > {2'b00, COUNT_MAX}) ? COUNT_MAX : sum[COUNT_W-1:0];
      res_d.last              = 1'b1;
    end else if (ctrl_i.empty) begin
      res_valid_d = 1'b1;
      res_d       = '0;
      res_d.last  = 1'b1;
    end else if (ctrl_i.dump) begin
      res_valid_d             = 1'b1;
      res_d.count_at_or_above = '0;
      res_d.out_key           = key_q[0];
      res_d.out_value         = val_q[0];
      res_d.out_valid         = 1'b1;
      res_d.last              = stat_o.dump_last;
      idx_d                   = stat_o.dump_last ? '0 : idx_q + IW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      idx_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      occ_q       <= occ_d;
      idx_q       <= idx_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      key_q[i] <= key_d[i];
      val_q[i] <= val_d[i];
    end
    if (ctrl_i.insert) begin
      thr_q <= req_i.threshold;
    end
    if (ctrl_i.flag) begin
      flag_q <= flag_d;
    end
    res_q <= res_d;
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

endmodule

`default_nettype wire
